[hdl/vsse_pkg.sv]
`timescale 1ns / 1ps
// shared constants and types for the voxel slice shell extractor
// no dependencies; used by vsse_outq and the top level

package vsse_pkg;

    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int VOXEL_W     = 16;
    localparam int IN_USER_W   = 1;
    localparam int OUT_TDATA_W = 8;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int MIN_DIM        = 2;

    localparam logic [CFG_W-1:0] RESET_IMAGE_WIDTH  = 11'd512;
    localparam logic [CFG_W-1:0] RESET_IMAGE_HEIGHT = 11'd512;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [IN_USER_W-1:0] OP_VOXEL = 1'b0;
    localparam logic [IN_USER_W-1:0] OP_FLUSH = 1'b1;

    localparam int OUTQ_DEPTH = 3;
    localparam int OUTQ_PTR_W = 2;
    localparam int OUTQ_CNT_W = 2;

    // line buffer word for one voxel: its own bit and its left, right and up neighbors
    typedef struct packed {
        logic up;
        logic right;
        logic mid;
        logic left;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic shell;
        logic end_of_slice;
    } result_t;

endpackage

[hdl/vsse_ram.sv]
`timescale 1ns / 1ps
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies

module vsse_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/vsse_outq.sv]
`timescale 1ns / 1ps
// small result queue that decouples the window logic from output backpressure
// depends on vsse_pkg

module vsse_outq (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_valid,
    input  vsse_pkg::result_t                   wr_data,
    output logic                                rd_valid,
    input  logic                                rd_ready,
    output vsse_pkg::result_t                   rd_data,
    output logic [vsse_pkg::OUTQ_CNT_W-1:0]     count
);

    localparam int PW = vsse_pkg::OUTQ_PTR_W;
    localparam int NW = vsse_pkg::OUTQ_CNT_W;
    localparam logic [PW-1:0] PTR_LAST = PW'(vsse_pkg::OUTQ_DEPTH - 1);

    vsse_pkg::result_t slots_reg [vsse_pkg::OUTQ_DEPTH];

    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [NW-1:0] count_reg;
    logic [NW-1:0] count_next;
    logic          pop;

    assign pop      = rd_valid & rd_ready;
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slots_reg[rd_ptr_reg];
    assign count    = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
        case ({wr_valid, pop})
            2'b10:   count_next = count_reg + NW'(1);
            2'b01:   count_next = count_reg - NW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_valid)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[hdl/voxel_slice_shell_extract.sv]
`timescale 1ns / 1ps
// voxel slice shell extractor top level: line buffer, window logic, result path
// depends on vsse_pkg, vsse_ram and vsse_outq

// Takes one request per clock while s_tready is high, voxel or flush. Each voxel
// is marked shell when it is nonzero and one of its in-slice left, right, up or down
// neighbors is zero; neighbors outside the slice, or not yet received when a flush answers
// a voxel, count as the voxel itself. The answer for a voxel leaves one row plus one voxel
// behind it in the stream, or on the flush request that drains it; once a request causes a
// result it passes s1_reg and then the result queue. A single line buffer memory,
// one read and one write per clock, holds one word per column; it needs no clearing after
// reset. Writing either size register restarts the stream and drops unanswered voxels.

module voxel_slice_shell_extract #(
    parameter int MAX_WIDTH  = vsse_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = vsse_pkg::DEF_MAX_HEIGHT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [vsse_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vsse_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [vsse_pkg::VOXEL_W-1:0]       s_tdata,   // voxel
    input  logic [vsse_pkg::IN_USER_W-1:0]     s_tuser,   // op
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [vsse_pkg::OUT_TDATA_W-1:0]   m_tdata,   // shell, zero fill
    output logic                               m_tlast
);

    localparam int CW    = vsse_pkg::CFG_W;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 2);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int NW    = vsse_pkg::OUTQ_CNT_W;
    localparam int OCC_W = NW + 1;
    localparam logic [NW-1:0] Q_FULL = NW'(vsse_pkg::OUTQ_DEPTH);

    typedef struct packed {
        logic from_ram;
        logic center;
        logic left;
        logic right;
        logic up;
        logic down;
        logic use_left;
        logic use_right;
        logic use_up;
        logic use_down;
        logic eos;
    } stage_t;

    logic [CW-1:0]    image_width_reg;
    logic [CW-1:0]    image_height_reg;
    logic [WW-1:0]    weff;
    logic [HW-1:0]    heff;

    logic [COL_W-1:0] in_col_reg;
    logic [COL_W-1:0] in_col_next;
    logic [COL_W-1:0] prev_col_reg;
    logic [COL_W-1:0] out_col_reg;
    logic [COL_W-1:0] out_col_next;
    logic [ROW_W-1:0] out_row_reg;
    logic [ROW_W-1:0] out_row_next;
    logic [WW-1:0]    pending_reg;
    logic [WW-1:0]    pending_next;
    logic             prev_valid_reg;
    logic             prev_valid_next;
    logic             last_bit_reg;
    logic             prev_bit_reg;
    logic             rd_push_reg;

    vsse_pkg::entry_t hold_reg;
    vsse_pkg::entry_t old_entry;
    vsse_pkg::entry_t ram_rdata;
    vsse_pkg::entry_t wr_entry;

    logic             ram_we;
    logic             ram_re;
    logic [COL_W-1:0] ram_waddr;
    logic [COL_W-1:0] ram_raddr;

    logic             in_fire;
    logic             is_push;
    logic             is_flush;
    logic             voxel_bit;
    logic             push_emit;
    logic             flush_emit;
    logic             flush_near;
    logic             emit;
    logic             in_row_end;
    logic             at_left;
    logic             at_right;
    logic             at_top;
    logic             at_bottom;

    stage_t           s1_reg;
    stage_t           s1_next;
    logic             s1_valid_reg;

    logic             c_bit;
    logic             l_bit;
    logic             r_bit;
    logic             u_bit;
    vsse_pkg::result_t s1_result;
    vsse_pkg::result_t q_head;
    logic [NW-1:0]    q_count;
    logic [OCC_W-1:0] occupancy;

    // effective slice size
    always_comb
    begin
        if (image_width_reg < CW'(vsse_pkg::MIN_DIM))
        begin
            weff = WW'(vsse_pkg::MIN_DIM);
        end
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
        begin
            weff = WW'(MAX_WIDTH);
        end
        else
        begin
            weff = WW'(image_width_reg);
        end

        if (image_height_reg < CW'(vsse_pkg::MIN_DIM))
        begin
            heff = HW'(vsse_pkg::MIN_DIM);
        end
        else if (32'(image_height_reg) > 32'(MAX_HEIGHT))
        begin
            heff = HW'(MAX_HEIGHT);
        end
        else
        begin
            heff = HW'(image_height_reg);
        end
    end

    assign occupancy = OCC_W'(q_count) + OCC_W'(s1_valid_reg);
    assign s_tready  = (occupancy < OCC_W'(vsse_pkg::OUTQ_DEPTH));

    assign in_fire    = s_tvalid & s_tready;
    assign is_push    = in_fire & (s_tuser == vsse_pkg::OP_VOXEL);
    assign is_flush   = in_fire & (s_tuser == vsse_pkg::OP_FLUSH);
    assign voxel_bit  = |s_tdata;
    assign push_emit  = is_push & (pending_reg > weff);
    assign flush_emit = is_flush & (pending_reg != '0);
    assign flush_near = (pending_reg == WW'(1));
    assign emit       = push_emit | flush_emit;

    assign in_row_end = (WW'(in_col_reg) == weff - WW'(1));
    assign at_left    = (out_col_reg == '0);
    assign at_right   = (WW'(out_col_reg) == weff - WW'(1));
    assign at_top     = (out_row_reg == '0);
    assign at_bottom  = (HW'(out_row_reg) == heff - HW'(1));

    // word read by the most recent voxel request
    assign old_entry = rd_push_reg ? ram_rdata : hold_reg;

    // line buffer access
    assign ram_re    = is_push | (flush_emit & ~flush_near);
    assign ram_raddr = is_push ? in_col_reg : out_col_reg;
    assign ram_we    = is_push & prev_valid_reg;
    assign ram_waddr = prev_col_reg;

    always_comb
    begin
        wr_entry.left  = prev_bit_reg;
        wr_entry.mid   = last_bit_reg;
        wr_entry.right = voxel_bit;
        wr_entry.up    = old_entry.mid;
    end

    vsse_ram #(
        .WIDTH (vsse_pkg::ENTRY_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // window set up for the voxel being answered
    always_comb
    begin
        s1_next.eos      = at_right & at_bottom;
        s1_next.use_left = ~at_left;
        s1_next.use_up   = ~at_top;
        s1_next.down     = last_bit_reg;
        if (is_push)
        begin
            s1_next.from_ram  = 1'b0;
            s1_next.center    = old_entry.mid;
            s1_next.left      = old_entry.left;
            s1_next.right     = old_entry.right;
            s1_next.up        = old_entry.up;
            s1_next.use_right = ~at_right;
            s1_next.use_down  = ~at_bottom;
        end
        else if (flush_near)
        begin
            // newest voxel: right and down not yet received
            s1_next.from_ram  = 1'b0;
            s1_next.center    = last_bit_reg;
            s1_next.left      = prev_bit_reg;
            s1_next.right     = last_bit_reg;
            s1_next.up        = old_entry.mid;
            s1_next.use_right = 1'b0;
            s1_next.use_down  = 1'b0;
        end
        else
        begin
            s1_next.from_ram  = 1'b1;
            s1_next.center    = 1'b0;
            s1_next.left      = 1'b0;
            s1_next.right     = 1'b0;
            s1_next.up        = 1'b0;
            s1_next.use_right = ~at_right;
            s1_next.use_down  = ~at_bottom & (pending_reg == weff + WW'(1));
        end
    end

    // counters and pending count
    always_comb
    begin
        in_col_next     = in_col_reg;
        out_col_next    = out_col_reg;
        out_row_next    = out_row_reg;
        pending_next    = pending_reg;
        prev_valid_next = prev_valid_reg;
        if (cfg_we)
        begin
            in_col_next     = '0;
            out_col_next    = '0;
            out_row_next    = '0;
            pending_next    = '0;
            prev_valid_next = 1'b0;
        end
        else
        begin
            if (is_push)
            begin
                in_col_next     = in_row_end ? '0 : in_col_reg + COL_W'(1);
                prev_valid_next = 1'b1;
                pending_next    = push_emit ? pending_reg : pending_reg + WW'(1);
            end
            else if (flush_emit)
            begin
                pending_next = pending_reg - WW'(1);
            end
            if (emit)
            begin
                if (at_right)
                begin
                    out_col_next = '0;
                    out_row_next = at_bottom ? '0 : out_row_reg + ROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= vsse_pkg::RESET_IMAGE_WIDTH;
            image_height_reg <= vsse_pkg::RESET_IMAGE_HEIGHT;
            in_col_reg       <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            pending_reg      <= '0;
            prev_valid_reg   <= 1'b0;
            rd_push_reg      <= 1'b0;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    vsse_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                    vsse_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                    default:                    image_width_reg  <= image_width_reg;
                endcase
            end
            in_col_reg     <= in_col_next;
            out_col_reg    <= out_col_next;
            out_row_reg    <= out_row_next;
            pending_reg    <= pending_next;
            prev_valid_reg <= prev_valid_next;
            rd_push_reg    <= is_push;
            s1_valid_reg   <= emit & ~cfg_we;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_push)
        begin
            prev_col_reg <= in_col_reg;
            last_bit_reg <= voxel_bit;
            prev_bit_reg <= last_bit_reg;
        end
        if (rd_push_reg)
        begin
            hold_reg <= ram_rdata;
        end
        if (emit)
        begin
            s1_reg <= s1_next;
        end
    end

    // shell decision
    assign c_bit = s1_reg.from_ram ? ram_rdata.mid   : s1_reg.center;
    assign l_bit = s1_reg.from_ram ? ram_rdata.left  : s1_reg.left;
    assign r_bit = s1_reg.from_ram ? ram_rdata.right : s1_reg.right;
    assign u_bit = s1_reg.from_ram ? ram_rdata.up    : s1_reg.up;

    always_comb
    begin
        s1_result.shell = c_bit & ((s1_reg.use_left  & ~l_bit) |
                                   (s1_reg.use_right & ~r_bit) |
                                   (s1_reg.use_up    & ~u_bit) |
                                   (s1_reg.use_down  & ~s1_reg.down));
        s1_result.end_of_slice = s1_reg.eos;
    end

    vsse_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (s1_valid_reg),
        .wr_data  (s1_result),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (q_head),
        .count    (q_count)
    );

    assign m_tdata = {{(vsse_pkg::OUT_TDATA_W - 1){1'b0}}, q_head.shell};
    assign m_tlast = q_head.end_of_slice;

`ifndef SYNTH
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pending_reg) <= 32'(weff) + 32'd1)
        else $error("pending count beyond one row plus one voxel");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("line buffer read and write hit the same column");

    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (q_count != Q_FULL))
        else $error("result queue full while a result is entering");

    a_out_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        WW'(out_col_reg) < weff)
        else $error("output column outside the slice");

    a_in_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        WW'(in_col_reg) < weff)
        else $error("input column outside the slice");
`endif

endmodule
